// ----- hdl/nlp_pkg.sv -----
// Shared types, character codes and token state definitions for the numeric literal parser.
package nlp_pkg;

    localparam int MAX_TOKEN = 32;
    localparam int POS_W     = $clog2(MAX_TOKEN + 1);
    localparam int BASE_W    = 5;
    localparam int VALUE_W   = 32;

    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
    localparam logic [7:0] CH_QUOTE  = 8'h27;  // single quote
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    localparam logic [BASE_W-1:0] BASE_2  = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_10 = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_16 = BASE_W'(16);

    typedef enum logic [1:0] {
        PFX_HASH   = 2'd0,
        PFX_DOLLAR = 2'd1,
        PFX_PCT    = 2'd2,
        PFX_DONE   = 2'd3
    } prefix_stage_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic               valid_res;
        logic [VALUE_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        prefix_stage_t      prefix_stage;
        logic [BASE_W-1:0]  active_base;
        logic               negative;
        logic               digits_seen;
        logic               failed;
        logic [VALUE_W-1:0] accumulator;
        logic [15:0]        first_chars;
    } token_state_t;

    localparam token_state_t TOKEN_CLEAR = '{
        position:     '0,
        prefix_stage: PFX_HASH,
        active_base:  BASE_10,
        negative:     1'b0,
        digits_seen:  1'b0,
        failed:       1'b0,
        accumulator:  '0,
        first_chars:  '0
    };

endpackage

// ----- hdl/nlp_in_reg.sv -----
// Input register stage that captures one character transfer and holds it until consumed.
module nlp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          character,
    input  logic                last_char,
    input  logic                advance,
    output logic                item_valid,
    output nlp_pkg::char_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    nlp_pkg::char_item_t item_reg;
    logic                load;

    // The stage can take a new character when it is empty or its item leaves now.
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.character <= character;
            item_reg.last_char <= last_char;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/nlp_parse_core.sv -----
// Token state registers and the per-character prefix, sign and digit step logic.
module nlp_parse_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  nlp_pkg::char_item_t                 item,
    input  logic [nlp_pkg::BASE_W-1:0]          default_base,
    output nlp_pkg::result_t                    result
);

    nlp_pkg::token_state_t st_reg;
    nlp_pkg::token_state_t st_next;
    nlp_pkg::token_state_t nx;

    logic [7:0]                   c;
    logic [nlp_pkg::POS_W-1:0]    pos;
    logic [nlp_pkg::BASE_W-1:0]   base;
    logic [15:0]                  fc;
    logic                         used;
    logic                         is_dec;
    logic                         dec_ok;
    logic                         is_hex_letter;
    logic                         digit_ok;
    logic [4:0]                   digit;
    logic [nlp_pkg::VALUE_W-1:0]  product;
    logic                         char_lit;
    logic                         num_ok;

    always_comb
    begin
        c    = item.character;
        pos  = st_reg.position;
        base = (pos == '0) ? default_base : st_reg.active_base;

        fc = st_reg.first_chars;
        if (pos == '0)
        begin
            fc = {8'h00, c};
        end
        else if (pos == nlp_pkg::POS_W'(1))
        begin
            fc = {c, st_reg.first_chars[7:0]};
        end

        // Digit decoding against the base in force for this character.
        is_dec        = c inside {[nlp_pkg::CH_0:nlp_pkg::CH_9]};
        dec_ok        = is_dec && ((base < nlp_pkg::BASE_10) ?
                                   ({1'b0, c[3:0]} < base) : 1'b1);
        is_hex_letter = (base == nlp_pkg::BASE_16) &&
                        (c inside {[nlp_pkg::CH_UA:nlp_pkg::CH_UF],
                                   [nlp_pkg::CH_LA:nlp_pkg::CH_LF]});
        digit_ok      = dec_ok || is_hex_letter;
        digit         = is_hex_letter ? (5'(c[3:0]) + 5'd9) : 5'(c[3:0]);
        product       = st_reg.accumulator * nlp_pkg::VALUE_W'(base);

        nx             = st_reg;
        nx.active_base = base;
        nx.first_chars = fc;
        used           = 1'b0;

        if (pos >= nlp_pkg::POS_W'(nlp_pkg::MAX_TOKEN))
        begin
            nx.failed = 1'b1;
        end
        else
        begin
            nx.position = pos + nlp_pkg::POS_W'(1);
            if (!st_reg.failed)
            begin
                // Prefix checks run in order; each stage is passed at most once.
                if (st_reg.prefix_stage == nlp_pkg::PFX_HASH && c == nlp_pkg::CH_HASH)
                begin
                    used              = 1'b1;
                    nx.active_base    = nlp_pkg::BASE_10;
                    nx.prefix_stage   = nlp_pkg::PFX_DOLLAR;
                end
                else if (st_reg.prefix_stage inside {nlp_pkg::PFX_HASH, nlp_pkg::PFX_DOLLAR}
                         && c == nlp_pkg::CH_DOLLAR)
                begin
                    used              = 1'b1;
                    nx.active_base    = nlp_pkg::BASE_16;
                    nx.prefix_stage   = nlp_pkg::PFX_PCT;
                end
                else if (st_reg.prefix_stage != nlp_pkg::PFX_DONE && c == nlp_pkg::CH_PCT)
                begin
                    used              = 1'b1;
                    nx.active_base    = nlp_pkg::BASE_2;
                    nx.prefix_stage   = nlp_pkg::PFX_DONE;
                end
                else
                begin
                    nx.prefix_stage   = nlp_pkg::PFX_DONE;
                end

                if (!used)
                begin
                    if (!st_reg.negative && !st_reg.digits_seen &&
                        c == nlp_pkg::CH_MINUS && base == nlp_pkg::BASE_10)
                    begin
                        nx.negative = 1'b1;
                    end
                    else if (digit_ok)
                    begin
                        nx.accumulator = product + nlp_pkg::VALUE_W'(digit);
                        nx.digits_seen = 1'b1;
                    end
                    else
                    begin
                        nx.failed = 1'b1;
                    end
                end
            end
        end

        // Token end: a quoted single byte wins over the numeric outcome.
        char_lit = (pos == nlp_pkg::POS_W'(2)) && (fc[7:0] == nlp_pkg::CH_QUOTE) &&
                   (c == nlp_pkg::CH_QUOTE);
        num_ok   = !nx.failed && nx.digits_seen;
        if (char_lit)
        begin
            result.valid_res = 1'b1;
            result.value     = nlp_pkg::VALUE_W'(fc[15:8]);
        end
        else if (num_ok)
        begin
            result.valid_res = 1'b1;
            result.value     = nx.negative ? (nlp_pkg::VALUE_W'(0) - nx.accumulator)
                                           : nx.accumulator;
        end
        else
        begin
            result.valid_res = 1'b0;
            result.value     = '0;
        end

        st_next = st_reg;
        if (step)
        begin
            st_next = item.last_char ? nlp_pkg::TOKEN_CLEAR : nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= nlp_pkg::TOKEN_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- hdl/numeric_literal_parser.sv -----
// Top level of the numeric literal parser: configuration register, pipeline control, result register.
//
// The parser takes one token character per transfer, with last_char set on the final
// character, and delivers one result transfer per token: valid_res and a 32-bit two's
// complement value (zero when invalid). A token of the form quote, byte, quote returns the
// byte; otherwise the prefixes '#', '$', '%' select base 10, 16 or 2, else default_base
// applies, and a leading '-' negates in base 10 only. Tokens longer than 32 characters are
// invalid. Throughput is one character per clock cycle while no token end waits for a full
// result register: the character passes an input register, the state update and a 32-by-5
// multiply-add on the accumulator, and the result of the last character lands in the result
// register, which raises out_valid; the result transfer completes at a clock edge with
// out_stall low. in_stall follows out_stall in the same cycle only when a token end waits
// for a full result register that is not being emptied. default_base is sampled at the
// first character of each token and should be written only while the parser is idle.
module numeric_literal_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          character,
    input  logic                last_char,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                valid_res,
    output logic signed [31:0]  value
);

    logic [nlp_pkg::BASE_W-1:0] default_base_reg;
    logic                       item_valid;
    nlp_pkg::char_item_t        item;
    logic                       out_free;
    logic                       advance;
    nlp_pkg::result_t           result;
    nlp_pkg::result_t           res_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       res_load;

    // Configuration register; the reset value is base ten.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_base_reg <= nlp_pkg::BASE_10;
        end
        else if (cfg_we)
        begin
            default_base_reg <= cfg_data;
        end
    end

    nlp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .last_char  (last_char),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // A character that is not a token end never needs the result register, so it
    // is consumed at once; a token end waits until the result register has room.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = item_valid && (!item.last_char || out_free);
    assign res_load = advance && item.last_char;

    nlp_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item),
        .default_base (default_base_reg),
        .result       (result)
    );

    // Result register: holds one result until its transfer completes.
    assign out_valid_next = res_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg.valid_res;
    assign value     = signed'(res_reg.value);

endmodule
